// File: hdl/lca_pkg.sv
package lca_pkg;

  // Field widths fixed by the item format
  localparam int NODE_W = 10;
  localparam int CFG_W  = 4;

  // Default sizes and register reset
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;
  localparam logic [CFG_W-1:0] TOP_RESET = 4'd9;

  // Read address source
  typedef enum logic [1:0] {
    RD_X,
    RD_Y,
    RD_FILL
  } rd_sel_t;

  // Level counter operation
  typedef enum logic [2:0] {
    LVL_HOLD,
    LVL_TOP,
    LVL_ONE,
    LVL_INC,
    LVL_DEC
  } lvl_op_t;

  // Result source
  typedef enum logic {
    OUT_X,
    OUT_ROW_X0
  } out_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    cap_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_x;
    logic    cap_y;
    logic    order;
    logic    lift_y;
    logic    lift_xy;
    logic    fill_set;
    logic    wr_row;
    logic    clr_wr;
    lvl_op_t lvl_op;
    logic    out_load;
    out_sel_t out_sel;
  } lca_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic in_load_ok;
    logic top_zero;
    logic lvl_at_top;
    logic lvl_zero;
    logic lift_bit;
    logic xy_equal;
    logic anc_ne;
    logic out_busy;
  } lca_stat_t;

endpackage

// File: hdl/lowest_common_ancestor_engine.sv
// Channel  Direction  Ports                                        Beat
// in       input      in_valid/in_ready, in_cmd, in_node_a,        one load or query
//                     in_node_b, in_depth
// out      output     out_valid/out_ready, out_ancestor            one result per query
// cfg      input      cfg_wr_en, cfg_wr_data                       top level, no wait
//
// Load: each filled level takes a table read and a capture through the single table read port.
// Query: each lift costs one table read per node.
// Reset: a clearing pass writes every table row, with in_ready low meanwhile.
// A result waits in the output register; the next beat is taken while it waits, and a
// query only stalls at its end if the previous result is still untaken.
module lowest_common_ancestor_engine #(
  parameter int NODES  = lca_pkg::NODES_DEF,
  parameter int LEVELS = lca_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [lca_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [lca_pkg::NODE_W-1:0] in_node_a,
  input  logic [lca_pkg::NODE_W-1:0] in_node_b,
  input  logic [lca_pkg::NODE_W-1:0] in_depth,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lca_pkg::NODE_W-1:0] out_ancestor
);

  lca_pkg::lca_cmd_t  cmd;
  lca_pkg::lca_stat_t stat;

  lca_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lca_datapath #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .in_depth     (in_depth),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_ancestor (out_ancestor),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// File: hdl/lca_datapath.sv
module lca_datapath #(
  parameter int NODES  = lca_pkg::NODES_DEF,
  parameter int LEVELS = lca_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [lca_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic [lca_pkg::NODE_W-1:0] in_node_a,
  input  logic [lca_pkg::NODE_W-1:0] in_node_b,
  input  logic [lca_pkg::NODE_W-1:0] in_depth,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [lca_pkg::NODE_W-1:0] out_ancestor,
  input  lca_pkg::lca_cmd_t          cmd,
  output lca_pkg::lca_stat_t         stat
);

  localparam int NW = lca_pkg::NODE_W;
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int RW = LEVELS * NW;
  localparam int MW = RW + NW;

  typedef logic [LEVELS-1:0][NW-1:0] row_t;

  // Table memory: one word per node, depth on top of the jump levels
  logic [MW-1:0] mem [NODES];

  logic [lca_pkg::CFG_W-1:0] cfg_r;
  logic [AW-1:0]             clr_cnt_r;
  logic                      out_valid_r;
  logic [NW-1:0]             out_anc_r;

  logic [NW-1:0] x_r, y_r, dep_r;
  logic [NW-1:0] dep_x_r, dep_y_r, diff_r;
  row_t          row_x_r, row_y_r, build_r;
  logic [LW-1:0] lvl_r;
  logic [MW-1:0] rd_q_r;
  logic          rd_oor_r;

  logic [LW-1:0] top;
  logic [LW-1:0] lvl_m1;
  logic [NW-1:0] rd_node;
  logic          rd_in_range;
  row_t          rd_row;
  logic [NW-1:0] rd_dep;
  logic [NW-1:0] fill_tgt;
  logic [NW-1:0] fill_val;
  logic [NW-1:0] diff_sh;

  // Clamp the top level to the table height
  assign top    = (32'(cfg_r) >= LEVELS) ? LW'(LEVELS - 1) : LW'(cfg_r);
  assign lvl_m1 = LW'(lvl_r - 1'b1);

  // Pick the node to read
  always_comb begin
    case (cmd.rd_sel)
      lca_pkg::RD_X:    rd_node = x_r;
      lca_pkg::RD_Y:    rd_node = y_r;
      lca_pkg::RD_FILL: rd_node = build_r[lvl_m1];
      default:          rd_node = x_r;
    endcase
  end

  assign rd_in_range = (32'(rd_node) < NODES);

  // Out-of-range nodes read as an all-zero word
  assign rd_row = rd_oor_r ? row_t'('0) : row_t'(rd_q_r[RW-1:0]);
  assign rd_dep = rd_oor_r ? '0 : rd_q_r[MW-1 -: NW];

  // Bypass a self reference to the row under construction
  assign fill_tgt = build_r[lvl_m1];
  assign fill_val = (fill_tgt == y_r) ? fill_tgt : rd_row[lvl_m1];

  assign diff_sh = NW'(diff_r >> lvl_r);

  // Memory ports
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.wr_row) begin
      mem[AW'(y_r)] <= {dep_r, RW'(build_r)};
    end
    if (cmd.rd_en) begin
      rd_q_r   <= mem[AW'(rd_node)];
      rd_oor_r <= !rd_in_range;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= lca_pkg::TOP_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= AW'(clr_cnt_r + 1'b1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      x_r     <= in_node_a;
      y_r     <= in_node_b;
      dep_r   <= in_depth;
      build_r <= row_t'(RW'(in_node_a));
    end
    if (cmd.cap_x) begin
      row_x_r <= rd_row;
      dep_x_r <= rd_dep;
    end
    if (cmd.cap_y) begin
      row_y_r <= rd_row;
      dep_y_r <= rd_dep;
    end
    // Put the shallower node in x
    if (cmd.order) begin
      if (dep_x_r > dep_y_r) begin
        x_r     <= y_r;
        y_r     <= x_r;
        row_x_r <= row_y_r;
        row_y_r <= row_x_r;
        dep_x_r <= dep_y_r;
        dep_y_r <= dep_x_r;
        diff_r  <= dep_x_r - dep_y_r;
      end else begin
        diff_r  <= dep_y_r - dep_x_r;
      end
    end
    if (cmd.lift_y) begin
      y_r <= row_y_r[lvl_r];
    end
    if (cmd.lift_xy) begin
      x_r <= row_x_r[lvl_r];
      y_r <= row_y_r[lvl_r];
    end
    if (cmd.fill_set) begin
      build_r[lvl_r] <= fill_val;
    end
    case (cmd.lvl_op)
      lca_pkg::LVL_TOP: lvl_r <= top;
      lca_pkg::LVL_ONE: lvl_r <= LW'(1);
      lca_pkg::LVL_INC: lvl_r <= LW'(lvl_r + 1'b1);
      lca_pkg::LVL_DEC: lvl_r <= LW'(lvl_r - 1'b1);
      default:          lvl_r <= lvl_r;
    endcase
    if (cmd.out_load) begin
      out_anc_r <= (cmd.out_sel == lca_pkg::OUT_X) ? x_r : row_x_r[0];
    end
  end

  // Status back to the controller
  assign stat.clr_last   = (32'(clr_cnt_r) == NODES - 1);
  assign stat.in_load_ok = (in_node_b != '0) && (32'(in_node_b) < NODES);
  assign stat.top_zero   = (top == '0);
  assign stat.lvl_at_top = (lvl_r == top);
  assign stat.lvl_zero   = (lvl_r == '0);
  assign stat.lift_bit   = diff_sh[0];
  assign stat.xy_equal   = (x_r == y_r);
  assign stat.anc_ne     = (row_x_r[lvl_r] != row_y_r[lvl_r]);
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_ancestor = out_anc_r;

endmodule

// File: hdl/lca_controller.sv
module lca_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  input  lca_pkg::lca_stat_t stat,
  output lca_pkg::lca_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LD_RD,
    S_LD_CAP,
    S_LD_WR,
    S_Q_RDX,
    S_Q_RDY,
    S_Q_CAPY,
    S_Q_ORD,
    S_Q_L1,
    S_Q_L1_RD,
    S_Q_L1_CAP,
    S_Q_CMP,
    S_Q_L2,
    S_Q_L2_RD,
    S_Q_L2_CAP,
    S_Q_L2_CAPY
  } state_t;

  localparam logic CMD_LOAD = 1'b0;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.rd_sel  = lca_pkg::RD_X;
    cmd.lvl_op  = lca_pkg::LVL_HOLD;
    cmd.out_sel = lca_pkg::OUT_X;
    in_ready    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          if (in_cmd == CMD_LOAD) begin
            if (!stat.in_load_ok) begin
              state_nxt = S_IDLE;
            end else if (stat.top_zero) begin
              state_nxt = S_LD_WR;
            end else begin
              cmd.lvl_op = lca_pkg::LVL_ONE;
              state_nxt  = S_LD_RD;
            end
          end else begin
            state_nxt = S_Q_RDX;
          end
        end
      end
      // Load: fetch the row named by the level below, one level per pass
      S_LD_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lca_pkg::RD_FILL;
        state_nxt  = S_LD_CAP;
      end
      S_LD_CAP: begin
        cmd.fill_set = 1'b1;
        if (stat.lvl_at_top) begin
          state_nxt = S_LD_WR;
        end else begin
          cmd.lvl_op = lca_pkg::LVL_INC;
          state_nxt  = S_LD_RD;
        end
      end
      S_LD_WR: begin
        cmd.wr_row = 1'b1;
        state_nxt  = S_IDLE;
      end
      // Query: fetch both rows
      S_Q_RDX: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lca_pkg::RD_X;
        state_nxt  = S_Q_RDY;
      end
      S_Q_RDY: begin
        cmd.cap_x  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lca_pkg::RD_Y;
        state_nxt  = S_Q_CAPY;
      end
      S_Q_CAPY: begin
        cmd.cap_y = 1'b1;
        state_nxt = S_Q_ORD;
      end
      S_Q_ORD: begin
        cmd.order  = 1'b1;
        cmd.lvl_op = lca_pkg::LVL_TOP;
        state_nxt  = S_Q_L1;
      end
      // Lift the deeper node by the depth difference
      S_Q_L1: begin
        if (stat.lift_bit) begin
          cmd.lift_y = 1'b1;
          state_nxt  = S_Q_L1_RD;
        end else if (stat.lvl_zero) begin
          state_nxt = S_Q_CMP;
        end else begin
          cmd.lvl_op = lca_pkg::LVL_DEC;
        end
      end
      S_Q_L1_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lca_pkg::RD_Y;
        state_nxt  = S_Q_L1_CAP;
      end
      S_Q_L1_CAP: begin
        cmd.cap_y = 1'b1;
        if (stat.lvl_zero) begin
          state_nxt = S_Q_CMP;
        end else begin
          cmd.lvl_op = lca_pkg::LVL_DEC;
          state_nxt  = S_Q_L1;
        end
      end
      S_Q_CMP: begin
        if (stat.xy_equal) begin
          if (!stat.out_busy) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = lca_pkg::OUT_X;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.lvl_op = lca_pkg::LVL_TOP;
          state_nxt  = S_Q_L2;
        end
      end
      // Lift both while their ancestors differ; hold the result while busy
      S_Q_L2: begin
        if (stat.anc_ne) begin
          cmd.lift_xy = 1'b1;
          state_nxt   = S_Q_L2_RD;
        end else if (!stat.lvl_zero) begin
          cmd.lvl_op = lca_pkg::LVL_DEC;
        end else if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = lca_pkg::OUT_ROW_X0;
          state_nxt    = S_IDLE;
        end
      end
      S_Q_L2_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lca_pkg::RD_X;
        state_nxt  = S_Q_L2_CAP;
      end
      S_Q_L2_CAP: begin
        cmd.cap_x  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lca_pkg::RD_Y;
        state_nxt  = S_Q_L2_CAPY;
      end
      // Step down a level, or finish after a lift at the lowest level
      S_Q_L2_CAPY: begin
        cmd.cap_y = 1'b1;
        if (!stat.lvl_zero) begin
          cmd.lvl_op = lca_pkg::LVL_DEC;
          state_nxt  = S_Q_L2;
        end else if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = lca_pkg::OUT_ROW_X0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/lca_checker.sv
module lca_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lca_pkg::NODE_W-1:0] out_ancestor
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ancestor))
    else $error("result beat dropped or changed while stalled");

  // Keep the input closed right after reset, as the clearing pass begins
  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // Run one query at a time
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd |=> !in_ready)
    else $error("input open while a query runs");

  // Produce no result from a load
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_cmd && !out_valid |=> !out_valid)
    else $error("result after a load");

endmodule

bind lowest_common_ancestor_engine lca_checker u_lca_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_cmd       (in_cmd),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_ancestor (out_ancestor)
);
